[design/svu_pkg.sv]
package svu_pkg;

  // Strip geometry
  localparam int STRIP_LENGTH = 24;
  localparam int HALF         = STRIP_LENGTH / 2;

  // Field widths
  localparam int IDX_W   = 6;
  localparam int LVL_W   = 8;
  localparam int DECAY_W = 11;
  localparam int PEAK_W  = 14;
  localparam int COLOR_W = 8;

  // Lit count holds 0..HALF, peak position holds 0..HALF-1
  localparam int LIT_W = $clog2(HALF + 1);
  localparam int POS_W = (HALF > 1) ? $clog2(HALF) : 1;

  localparam logic [DECAY_W-1:0] DECAY_RESET = DECAY_W'(111);

  localparam logic [COLOR_W-1:0] BAR_GREY = COLOR_W'(220);
  localparam logic [COLOR_W-1:0] PEAK_RED = COLOR_W'(255);
  localparam logic [COLOR_W-1:0] GLOW_RED = COLOR_W'(180);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STRIP_LENGTH - 1);
  localparam logic [IDX_W-1:0] HALF_IDX = IDX_W'(HALF);

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } pixel_t;

  // floor(lvl * HALF * 256 / 255) = m + floor(m / 255), m = lvl * HALF.
  // m / 255 uses (m + 1 + (m >> 8)) >> 8, exact for m below 65535.
  function automatic logic [PEAK_W-1:0] bar_fixed(input logic [LVL_W-1:0] lvl);
    logic [PEAK_W-1:0] m;
    logic [PEAK_W-1:0] q;
    m = PEAK_W'(lvl) * PEAK_W'(HALF);
    q = (m + PEAK_W'(1) + (m >> 8)) >> 8;
    return m + q;
  endfunction

  // Peak marker position: integer part, capped at HALF-1
  function automatic logic [POS_W-1:0] peak_pos(input logic [PEAK_W-1:0] peak);
    logic [PEAK_W-9:0] p;
    p = peak[PEAK_W-1:8];
    if (p >= (PEAK_W - 8)'(HALF)) begin
      p = (PEAK_W - 8)'(HALF - 1);
    end
    return POS_W'(p);
  endfunction

endpackage

[design/stereo_led_vu_meter_peak_hold_core.sv]
// Channel | Direction | Handshake              | Payload
// --------+-----------+------------------------+-------------------------------------------
// in      | input     | in_valid / in_ready    | in_level_left, in_level_right
// out     | output    | out_valid / out_ready  | out_pixel_index, out_red/green/blue,
//         |           |                        | out_last_pixel
// cfg     | input     | cfg_wr_en (no wait)    | cfg_wr_data (decay_step)
//
// One request yields STRIP_LENGTH pixels, one per cycle while out_ready stays
// high; the pixel counter steps through them.
// A request is held in an input register and loaded into the frame registers
// in the same cycle the previous frame's last pixel moves out, so frames
// stream with no gap. A stall on out_ready freezes the pixel counter.
// rst_n is synchronous, active low: clears peaks, control state and sets
// decay_step to 111 (0.43 pixel per frame).
module stereo_led_vu_meter_peak_hold_core (
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [svu_pkg::LVL_W-1:0]   in_level_left,
  input  logic [svu_pkg::LVL_W-1:0]   in_level_right,

  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [svu_pkg::IDX_W-1:0]   out_pixel_index,
  output logic [svu_pkg::COLOR_W-1:0] out_red,
  output logic [svu_pkg::COLOR_W-1:0] out_green,
  output logic [svu_pkg::COLOR_W-1:0] out_blue,
  output logic                        out_last_pixel,

  input  logic                        cfg_wr_en,
  input  logic [svu_pkg::DECAY_W-1:0] cfg_wr_data
);

  // Config register
  logic [svu_pkg::DECAY_W-1:0] decay_r;

  // Input request register
  logic                      req_vld_r;
  logic [svu_pkg::LVL_W-1:0] lvl_l_r;
  logic [svu_pkg::LVL_W-1:0] lvl_r_r;

  // Peak state (8 fraction bits)
  logic [svu_pkg::PEAK_W-1:0] peak_l_r, peak_l_nxt;
  logic [svu_pkg::PEAK_W-1:0] peak_r_r, peak_r_nxt;

  // Frame registers: what the pixel generator draws from
  logic                      act_r;
  logic [svu_pkg::IDX_W-1:0] cnt_r;
  logic [svu_pkg::LIT_W-1:0] lit_l_r, lit_r_r;
  logic [svu_pkg::POS_W-1:0] pk_l_r, pk_r_r;

  // Output register
  logic                      out_vld_r;
  logic [svu_pkg::IDX_W-1:0] idx_r;
  svu_pkg::pixel_t           pix_r, pix_nxt;
  logic                      last_r;

  logic [svu_pkg::PEAK_W-1:0] bar_l, bar_r;
  logic out_stall, adv, last_cnt, frame_done, load;

  assign out_stall  = out_vld_r && !out_ready;
  assign adv        = act_r && !out_stall;
  assign last_cnt   = (cnt_r == svu_pkg::LAST_IDX);
  assign frame_done = adv && last_cnt;
  assign load       = req_vld_r && (!act_r || frame_done);
  assign in_ready   = !req_vld_r || load;

  // Bar lengths and peak update for the waiting request
  assign bar_l = svu_pkg::bar_fixed(lvl_l_r);
  assign bar_r = svu_pkg::bar_fixed(lvl_r_r);

  always_comb begin
    if (bar_l > peak_l_r) begin
      peak_l_nxt = bar_l;
    end else if (peak_l_r > svu_pkg::PEAK_W'(decay_r)) begin
      peak_l_nxt = peak_l_r - svu_pkg::PEAK_W'(decay_r);
    end else begin
      peak_l_nxt = '0;
    end
    if (bar_r > peak_r_r) begin
      peak_r_nxt = bar_r;
    end else if (peak_r_r > svu_pkg::PEAK_W'(decay_r)) begin
      peak_r_nxt = peak_r_r - svu_pkg::PEAK_W'(decay_r);
    end else begin
      peak_r_nxt = '0;
    end
  end

  // Pixel generator: channel select, then grey bar, red peak, dark red glow
  logic [svu_pkg::IDX_W-1:0] pos, lit, pk, pk_inc;
  logic                      in_left;

  always_comb begin
    in_left = (cnt_r < svu_pkg::HALF_IDX);
    if (in_left) begin
      pos = cnt_r;
      lit = svu_pkg::IDX_W'(lit_l_r);
      pk  = svu_pkg::IDX_W'(pk_l_r);
    end else begin
      pos = cnt_r - svu_pkg::HALF_IDX;
      lit = svu_pkg::IDX_W'(lit_r_r);
      pk  = svu_pkg::IDX_W'(pk_r_r);
    end
    pk_inc  = pk + svu_pkg::IDX_W'(1);
    pix_nxt = '0;
    if (pos < svu_pkg::HALF_IDX && pos < lit) begin
      pix_nxt.red   = svu_pkg::BAR_GREY;
      pix_nxt.green = svu_pkg::BAR_GREY;
      pix_nxt.blue  = svu_pkg::BAR_GREY;
    end
    if (pk != '0 && pos == pk) begin
      pix_nxt       = '0;
      pix_nxt.red   = svu_pkg::PEAK_RED;
    end
    if (pk != '0 && pos == pk_inc) begin
      pix_nxt       = '0;
      pix_nxt.red   = svu_pkg::GLOW_RED;
    end
  end

  // Control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r   <= svu_pkg::DECAY_RESET;
      req_vld_r <= 1'b0;
      peak_l_r  <= '0;
      peak_r_r  <= '0;
      act_r     <= 1'b0;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        decay_r <= cfg_wr_data;
      end

      if (in_valid && in_ready) begin
        req_vld_r <= 1'b1;
      end else if (load) begin
        req_vld_r <= 1'b0;
      end

      if (load) begin
        peak_l_r <= peak_l_nxt;
        peak_r_r <= peak_r_nxt;
        act_r    <= 1'b1;
        cnt_r    <= '0;
      end else if (frame_done) begin
        act_r    <= 1'b0;
      end else if (adv) begin
        cnt_r    <= cnt_r + svu_pkg::IDX_W'(1);
      end

      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      lvl_l_r <= in_level_left;
      lvl_r_r <= in_level_right;
    end
    if (load) begin
      lit_l_r <= svu_pkg::LIT_W'(bar_l >> 8);
      lit_r_r <= svu_pkg::LIT_W'(bar_r >> 8);
      pk_l_r  <= svu_pkg::peak_pos(peak_l_nxt);
      pk_r_r  <= svu_pkg::peak_pos(peak_r_nxt);
    end
    if (adv) begin
      idx_r  <= cnt_r;
      pix_r  <= pix_nxt;
      last_r <= last_cnt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_pixel_index = idx_r;
  assign out_red         = pix_r.red;
  assign out_green       = pix_r.green;
  assign out_blue        = pix_r.blue;
  assign out_last_pixel  = last_r;

endmodule

[design/svu_checker.sv]
module svu_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [svu_pkg::IDX_W-1:0]   out_pixel_index,
  input logic [svu_pkg::COLOR_W-1:0] out_red,
  input logic [svu_pkg::COLOR_W-1:0] out_green,
  input logic [svu_pkg::COLOR_W-1:0] out_blue,
  input logic                        out_last_pixel
);

  // Reset empties the output register
  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // Stalled pixel holds its index, red value and last flag
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_index)
      && $stable(out_red) && $stable(out_last_pixel))
    else $error("stalled pixel changed");

  // Last flag marks exactly the final strip position
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_pixel == (out_pixel_index == svu_pkg::LAST_IDX)))
    else $error("last_pixel mismatch");

  // Only grey, or black green and blue (black or any shade of red)
  a_palette: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_green == out_blue) &&
      ((out_green == '0) || (out_green == svu_pkg::BAR_GREY && out_red == svu_pkg::BAR_GREY)))
    else $error("illegal pixel color");

  // Consecutive pixels of a frame are in index order
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_pixel ##1 out_valid
      |-> out_pixel_index == $past(out_pixel_index) + svu_pkg::IDX_W'(1))
    else $error("pixel index out of order");

endmodule

bind stereo_led_vu_meter_peak_hold_core svu_checker u_svu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_pixel_index (out_pixel_index),
  .out_red         (out_red),
  .out_green       (out_green),
  .out_blue        (out_blue),
  .out_last_pixel  (out_last_pixel)
);
